### rtl/ppte_pkg.sv
`timescale 1ns / 1ps
package ppte_pkg;
  localparam int unsigned MaxSegments = 16;
  localparam int unsigned MaxOrder    = 5;
  localparam int unsigned NumVehicles = 4;
  localparam int unsigned SegW   = $clog2(MaxSegments);
  localparam int unsigned VehW   = 2;
  localparam int unsigned SlotW  = VehW + SegW;
  localparam int unsigned CoefW  = SlotW + 3;
  localparam int unsigned CoefDepth = NumVehicles * MaxSegments * 8;

  typedef enum logic [2:0] {
    REQ_HEADER   = 3'd0,
    REQ_COEF     = 3'd1,
    REQ_META     = 3'd2,
    REQ_FALLBACK = 3'd3,
    REQ_QUERY    = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_WAIT, ST_EVAL, ST_MUL, ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        used_fallback;
    logic [3:0]  segment_used;
    logic        clamped_end;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

### rtl/ppte_if.sv
`timescale 1ns / 1ps
interface ppte_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [1:0]  vehicle;
  logic [3:0]  seg_index;
  logic [2:0]  power;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic signed [31:0] value_z;
  logic [31:0] seg_duration;
  logic [2:0]  seg_order;
  logic [4:0]  seg_count;
  logic [47:0] time_stamp;
  modport source(output valid, req_type, vehicle, seg_index, power, value_x, value_y,
                 value_z, seg_duration, seg_order, seg_count, time_stamp, input ready);
  modport sink(input valid, req_type, vehicle, seg_index, power, value_x, value_y,
               value_z, seg_duration, seg_order, seg_count, time_stamp, output ready);
endinterface

interface ppte_res_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        used_fallback;
  logic [3:0]  segment_used;
  logic        clamped_end;
  modport source(output valid, pos_x, pos_y, pos_z, used_fallback, segment_used,
                 clamped_end, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, used_fallback, segment_used,
               clamped_end, output ready);
endinterface

### rtl/ppte_horner.sv
`timescale 1ns / 1ps
// One Horner step: registered multiply, then combinational floor shift, add, saturate.
module ppte_horner (
  input  logic               clk_i,
  input  logic signed [31:0] acc_i,
  input  logic [31:0]        t_i,
  input  logic signed [31:0] c_i,
  output logic signed [31:0] acc_o
);
  logic signed [64:0] prod_q;
  logic signed [64:0] shifted;
  always_ff @(posedge clk_i) begin
    prod_q <= 65'(acc_i) * $signed({33'd0, t_i});
  end
  // arithmetic shift is floor division by 2^16
  assign shifted = prod_q >>> 16;
  assign acc_o = ppte_pkg::sat32(shifted + 65'(c_i));
endmodule

### rtl/piecewise_poly_trajectory_eval.sv
`timescale 1ns / 1ps
// Channel | Dir | Beat
// req     | in  | one load or query item per beat
// res     | out | one position per query beat
// A query walks the segments (duration read, then compare; up to 16), then steps through
// the Horner coefficients (coefficient read, then fold; order + 1, up to 6), then writes
// the output register. The walk is paced by the duration memory read and the evaluation
// by the per-axis multiplier loop.
// A fallback query skips walk and evaluation and goes straight to output.
// Reset clears counts, start times, fallbacks and written flags; memories need none.
// A stalled result holds in the output register; requests wait until it drains.
module piecewise_poly_trajectory_eval (
  input logic clk_i,
  input logic rst_ni,
  ppte_req_if.sink   req_i,
  ppte_res_if.source res_o
);
  localparam int unsigned Slots = ppte_pkg::NumVehicles * ppte_pkg::MaxSegments;

  // memories (synchronous, registered read)
  logic [31:0] dur_mem [Slots];
  logic [2:0]  ord_mem [Slots];
  logic [95:0] coef_mem [ppte_pkg::CoefDepth];

  logic [Slots-1:0]  written_q;
  logic [4:0]  total_q [ppte_pkg::NumVehicles];
  logic [47:0] start_q [ppte_pkg::NumVehicles];
  logic [95:0] fb_q [ppte_pkg::NumVehicles];

  ppte_pkg::state_e state_q, state_d;
  logic [1:0]  veh_q;
  logic [3:0]  seg_q;
  logic [47:0] trel_q;
  logic [48:0] accum_q;
  logic        clamp_q;
  logic [31:0] tloc_q;
  logic [2:0]  pw_q;
  logic        mul_q;
  logic signed [31:0] ax_q, ay_q, az_q;
  logic [31:0] dur_rd;
  logic [2:0]  ord_rd;
  logic [95:0] coef_rd;
  logic        res_v_q;
  ppte_pkg::res_t res_q;

  logic accept;
  logic [ppte_pkg::SlotW-1:0] wslot, rslot;
  logic [ppte_pkg::CoefW-1:0] raddr;
  logic [4:0]  tot;
  logic        all_written;
  logic [48:0] seg_end;
  logic        last_seg;
  logic signed [31:0] nx, ny, nz;

  assign req_i.ready = (state_q == ppte_pkg::ST_IDLE) && !res_v_q;
  assign accept = req_i.valid && req_i.ready;
  assign wslot = {req_i.vehicle, req_i.seg_index};
  assign rslot = {veh_q, seg_q};
  assign raddr = {rslot, pw_q};
  assign tot = total_q[req_i.vehicle];

  // every segment below the count must have its duration written
  always_comb begin
    all_written = 1'b1;
    for (int s = 0; s < ppte_pkg::MaxSegments; s++) begin
      if (5'(s) < tot && !written_q[{req_i.vehicle, ppte_pkg::SegW'(s)}]) begin
        all_written = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == ppte_pkg::REQ_HEADER) begin
      dur_mem[wslot] <= req_i.seg_duration;
      ord_mem[wslot] <= (req_i.seg_order > 3'(ppte_pkg::MaxOrder)) ?
                        3'(ppte_pkg::MaxOrder) : req_i.seg_order;
    end
    if (accept && req_i.req_type == ppte_pkg::REQ_COEF && req_i.power <= 3'(ppte_pkg::MaxOrder))
    begin
      coef_mem[{wslot, req_i.power}] <= {req_i.value_x, req_i.value_y, req_i.value_z};
    end
    dur_rd  <= dur_mem[rslot];
    ord_rd  <= ord_mem[rslot];
    coef_rd <= coef_mem[raddr];
  end

  assign seg_end  = accum_q + 49'(dur_rd);
  assign last_seg = (5'(seg_q) + 5'd1) >= total_q[veh_q];

  ppte_horner u_hx (.clk_i, .acc_i(ax_q), .t_i(tloc_q), .c_i(coef_rd[95:64]), .acc_o(nx));
  ppte_horner u_hy (.clk_i, .acc_i(ay_q), .t_i(tloc_q), .c_i(coef_rd[63:32]), .acc_o(ny));
  ppte_horner u_hz (.clk_i, .acc_i(az_q), .t_i(tloc_q), .c_i(coef_rd[31:0]), .acc_o(nz));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppte_pkg::ST_IDLE:
        if (accept && req_i.req_type == ppte_pkg::REQ_QUERY) begin
          state_d = (tot != 5'd0 && all_written) ? ppte_pkg::ST_WALK : ppte_pkg::ST_OUT;
        end
      ppte_pkg::ST_WALK: state_d = ppte_pkg::ST_WAIT;
      // segment found: pass through MUL, fetching c[order], before the first step
      ppte_pkg::ST_WAIT:
        if (49'(trel_q) <= seg_end || last_seg) state_d = ppte_pkg::ST_MUL;
        else state_d = ppte_pkg::ST_WALK;
      ppte_pkg::ST_EVAL:
        state_d = (pw_q == 3'd0) ? ppte_pkg::ST_OUT : ppte_pkg::ST_MUL;
      ppte_pkg::ST_MUL: state_d = ppte_pkg::ST_EVAL;
      ppte_pkg::ST_OUT: state_d = ppte_pkg::ST_IDLE;
      default: state_d = ppte_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ppte_pkg::ST_IDLE;
      written_q <= '0;
      res_v_q   <= 1'b0;
      for (int v = 0; v < ppte_pkg::NumVehicles; v++) begin
        total_q[v] <= '0;
        start_q[v] <= '0;
        fb_q[v]    <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        unique case (req_i.req_type)
          ppte_pkg::REQ_HEADER: written_q[wslot] <= 1'b1;
          ppte_pkg::REQ_META: begin
            total_q[req_i.vehicle] <= (req_i.seg_count > 5'(ppte_pkg::MaxSegments)) ?
                                      5'(ppte_pkg::MaxSegments) : req_i.seg_count;
            start_q[req_i.vehicle] <= req_i.time_stamp;
          end
          ppte_pkg::REQ_FALLBACK:
            fb_q[req_i.vehicle] <= {req_i.value_x, req_i.value_y, req_i.value_z};
          default: ;
        endcase
      end
      if (state_q == ppte_pkg::ST_OUT) res_v_q <= 1'b1;
      else if (res_o.valid && res_o.ready) res_v_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ppte_pkg::ST_IDLE:
        // capture only on an accepted beat; a waiting result must hold
        if (accept) begin
          veh_q   <= req_i.vehicle;
          seg_q   <= '0;
          accum_q <= '0;
          clamp_q <= 1'b0;
          pw_q    <= '0;
          mul_q   <= 1'b0;
          trel_q  <= (req_i.time_stamp > start_q[req_i.vehicle]) ?
                     req_i.time_stamp - start_q[req_i.vehicle] : '0;
          res_q   <= {fb_q[req_i.vehicle], 1'b1, 4'd0, 1'b0};
        end
      ppte_pkg::ST_WAIT: begin
        if (49'(trel_q) <= seg_end) begin
          tloc_q <= 32'(49'(trel_q) - accum_q);
          pw_q   <= ord_rd;
        end else if (last_seg) begin
          tloc_q  <= dur_rd;
          clamp_q <= 1'b1;
          pw_q    <= ord_rd;
        end else begin
          accum_q <= seg_end;
          seg_q   <= seg_q + 4'd1;
        end
      end
      ppte_pkg::ST_EVAL: begin
        // coef_rd holds c[pw_q]; first step loads, later steps fold in
        if (!mul_q) begin
          ax_q <= coef_rd[95:64];
          ay_q <= coef_rd[63:32];
          az_q <= coef_rd[31:0];
        end else begin
          ax_q <= nx;
          ay_q <= ny;
          az_q <= nz;
        end
        if (pw_q != 3'd0) pw_q <= pw_q - 3'd1;
        mul_q <= 1'b1;
      end
      ppte_pkg::ST_OUT:
        if (mul_q) res_q <= {ax_q, ay_q, az_q, 1'b0, seg_q, clamp_q};
      default: ;
    endcase
  end

  assign res_o.valid         = res_v_q;
  assign res_o.pos_x         = res_q.pos_x;
  assign res_o.pos_y         = res_q.pos_y;
  assign res_o.pos_z         = res_q.pos_z;
  assign res_o.used_fallback = res_q.used_fallback;
  assign res_o.segment_used  = res_q.segment_used;
  assign res_o.clamped_end   = res_q.clamped_end;

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ppte_pkg::ST_IDLE |-> !req_i.ready) else $error("ready while busy");
  a_out_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ppte_pkg::ST_OUT |=> res_o.valid) else $error("result lost");
  a_fb_seg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.used_fallback |-> res_o.segment_used == 4'd0 && !res_o.clamped_end)
    else $error("fallback flags");
endmodule

### tb/sv/piecewise_poly_trajectory_eval_tb.sv
`timescale 1ns / 1ps
module piecewise_poly_trajectory_eval_tb;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 550;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumPowers = ppte_pkg::MaxOrder + 1;

  // One request beat as the testbench builds it.
  typedef struct {
    logic [2:0]  req;
    logic [1:0]  veh;
    logic [3:0]  seg;
    logic [2:0]  pw;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] dur;
    logic [2:0]  ord;
    logic [4:0]  cnt;
    logic [47:0] ts;
  } beat_t;

  // Shadow copy of the trajectory stores plus the queue of positions still owed.
  class traj_scoreboard;
    logic signed [31:0] coef [3][ppte_pkg::NumVehicles][ppte_pkg::MaxSegments][NumPowers];
    bit          coef_ok [ppte_pkg::NumVehicles][ppte_pkg::MaxSegments][NumPowers];
    logic [31:0] dur_mem [ppte_pkg::NumVehicles][ppte_pkg::MaxSegments];
    int unsigned ord_mem [ppte_pkg::NumVehicles][ppte_pkg::MaxSegments];
    bit          dur_ok [ppte_pkg::NumVehicles][ppte_pkg::MaxSegments];
    int unsigned seg_total [ppte_pkg::NumVehicles];
    logic [47:0] start_ts [ppte_pkg::NumVehicles];
    logic [31:0] fb_pos [ppte_pkg::NumVehicles][3];
    ppte_pkg::res_t owed_pos [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      foreach (coef_ok[v, s, p]) coef_ok[v][s][p] = 0;
      foreach (dur_ok[v, s]) begin
        dur_ok[v][s] = 0;
        dur_mem[v][s] = '0;
        ord_mem[v][s] = 0;
      end
      foreach (seg_total[v]) begin
        seg_total[v] = 0;
        start_ts[v] = '0;
        for (int a = 0; a < 3; a++) fb_pos[v][a] = '0;
      end
    endfunction

    function bit traj_valid(int v);
      if (seg_total[v] == 0) return 0;
      for (int s = 0; s < seg_total[v]; s++)
        if (!dur_ok[v][s]) return 0;
      return 1;
    endfunction

    // Walk the segments: first one whose running end covers the relative time.
    function void locate(int v, logic [47:0] ts, output int seg, output bit clamped,
                         output logic [31:0] tloc);
      longint trel, accum;
      trel = (ts > start_ts[v]) ? longint'(ts - start_ts[v]) : 0;
      accum = 0;
      clamped = 0;
      for (seg = 0; seg < int'(seg_total[v]); seg++) begin
        if (trel <= accum + longint'(dur_mem[v][seg])) break;
        accum += longint'(dur_mem[v][seg]);
      end
      if (seg >= int'(seg_total[v])) begin
        seg = seg_total[v] - 1;
        tloc = dur_mem[v][seg];
        clamped = 1;
      end else begin
        tloc = 32'(trel - accum);
      end
    endfunction

    function longint span(int v);
      longint sum;
      sum = 0;
      for (int s = 0; s < seg_total[v]; s++) sum += longint'(dur_mem[v][s]);
      return sum;
    endfunction

    // A query is safe to send unless it would read a coefficient never written.
    function bit query_safe(int v, logic [47:0] ts);
      int seg;
      bit clamped;
      logic [31:0] tloc;
      if (!traj_valid(v)) return 1;
      locate(v, ts, seg, clamped, tloc);
      for (int p = 0; p <= int'(ord_mem[v][seg]); p++)
        if (!coef_ok[v][seg][p]) return 0;
      return 1;
    endfunction

    // Horner with floor of the Q16.16 product and saturation at each step.
    function logic [31:0] horner_axis(int a, int v, int s, int ord, logic [31:0] t);
      longint acc, prod, tt;
      acc = coef[a][v][s][ord];
      tt = {32'd0, t};
      for (int j = ord - 1; j >= 0; j--) begin
        prod = (acc * tt) >>> 16;
        prod += longint'(coef[a][v][s][j]);
        if (prod > 64'sd2147483647) acc = 64'sd2147483647;
        else if (prod < -64'sd2147483648) acc = -64'sd2147483648;
        else acc = prod;
      end
      return acc[31:0];
    endfunction

    function void note(beat_t b);
      int v, seg;
      bit clamped;
      logic [31:0] tloc;
      ppte_pkg::res_t r;
      v = b.veh;
      case (b.req)
        ppte_pkg::REQ_HEADER: begin
          dur_mem[v][b.seg] = b.dur;
          ord_mem[v][b.seg] = (b.ord > ppte_pkg::MaxOrder) ? ppte_pkg::MaxOrder : b.ord;
          dur_ok[v][b.seg] = 1;
        end
        ppte_pkg::REQ_COEF: begin
          if (b.pw <= ppte_pkg::MaxOrder) begin
            coef[0][v][b.seg][b.pw] = b.vx;
            coef[1][v][b.seg][b.pw] = b.vy;
            coef[2][v][b.seg][b.pw] = b.vz;
            coef_ok[v][b.seg][b.pw] = 1;
          end
        end
        ppte_pkg::REQ_META: begin
          seg_total[v] = (b.cnt > ppte_pkg::MaxSegments) ? ppte_pkg::MaxSegments : b.cnt;
          start_ts[v] = b.ts;
        end
        ppte_pkg::REQ_FALLBACK: begin
          fb_pos[v][0] = b.vx;
          fb_pos[v][1] = b.vy;
          fb_pos[v][2] = b.vz;
        end
        ppte_pkg::REQ_QUERY: begin
          if (!traj_valid(v)) begin
            r = '{pos_x: fb_pos[v][0], pos_y: fb_pos[v][1], pos_z: fb_pos[v][2],
                  used_fallback: 1'b1, segment_used: 4'd0, clamped_end: 1'b0};
          end else begin
            locate(v, b.ts, seg, clamped, tloc);
            r.pos_x = horner_axis(0, v, seg, ord_mem[v][seg], tloc);
            r.pos_y = horner_axis(1, v, seg, ord_mem[v][seg], tloc);
            r.pos_z = horner_axis(2, v, seg, ord_mem[v][seg], tloc);
            r.used_fallback = 1'b0;
            r.segment_used = 4'(seg);
            r.clamped_end = clamped;
          end
          owed_pos = {owed_pos, r};
        end
        default: ;
      endcase
    endfunction

    function void check(ppte_pkg::res_t got);
      ppte_pkg::res_t want;
      if (owed_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected position beat: %p", got);
        return;
      end
      want = owed_pos.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.pos_z !== want.pos_z || got.used_fallback !== want.used_fallback ||
          got.segment_used !== want.segment_used || got.clamped_end !== want.clamped_end)
      begin
        mismatches++;
        if (mismatches <= 10) $display("position mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ppte_req_if req_if();
  ppte_res_if res_if();

  piecewise_poly_trajectory_eval uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if)
  );

  traj_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit quiet = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every accepted position beat against the oldest owed one.
  always @(posedge clk) begin
    ppte_pkg::res_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.pos_x = res_if.pos_x;
      got.pos_y = res_if.pos_y;
      got.pos_z = res_if.pos_z;
      got.used_fallback = res_if.used_fallback;
      got.segment_used = res_if.segment_used;
      got.clamped_end = res_if.clamped_end;
      sb.check(got);
    end
  end

  // Stall the result side in random bursts; hold ready high once quiet.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        res_if.ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      res_if.ready = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(5, 40)) @(negedge clk);
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Random filler for every field; callers override what matters.
  function automatic beat_t mk(logic [2:0] req, logic [1:0] veh);
    beat_t b;
    b.req = req;
    b.veh = veh;
    b.seg = 4'($urandom);
    b.pw = 3'($urandom);
    b.vx = $urandom;
    b.vy = $urandom;
    b.vz = $urandom;
    b.dur = $urandom;
    b.ord = 3'($urandom);
    b.cnt = 5'($urandom);
    b.ts = rand48();
    return b;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(0, 32'h3ffff)) - 32'h1ffff;
    endcase
  endfunction

  // Present one beat at the falling edge and hold it until accepted.
  task automatic send(beat_t b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid = 1'b1;
    req_if.req_type = b.req;
    req_if.vehicle = b.veh;
    req_if.seg_index = b.seg;
    req_if.power = b.pw;
    req_if.value_x = b.vx;
    req_if.value_y = b.vy;
    req_if.value_z = b.vz;
    req_if.seg_duration = b.dur;
    req_if.seg_order = b.ord;
    req_if.seg_count = b.cnt;
    req_if.time_stamp = b.ts;
    do @(posedge clk); while (!req_if.ready);
    sb.note(b);
    if (b.req <= ppte_pkg::REQ_QUERY && !(b.req == ppte_pkg::REQ_COEF &&
        b.pw > ppte_pkg::MaxOrder)) items_sent++;
  endtask

  // Skip a query that would touch an unwritten coefficient.
  task automatic query(logic [1:0] veh, logic [47:0] ts);
    beat_t b;
    b = mk(ppte_pkg::REQ_QUERY, veh);
    b.ts = ts;
    if (sb.query_safe(veh, ts)) send(b);
  endtask

  task automatic header(logic [1:0] veh, int seg, logic [31:0] dur, logic [2:0] ord);
    beat_t b;
    b = mk(ppte_pkg::REQ_HEADER, veh);
    b.seg = 4'(seg);
    b.dur = dur;
    b.ord = ord;
    send(b);
  endtask

  task automatic coefw(logic [1:0] veh, int seg, int pw, logic [31:0] vx, logic [31:0] vy,
                       logic [31:0] vz);
    beat_t b;
    b = mk(ppte_pkg::REQ_COEF, veh);
    b.seg = 4'(seg);
    b.pw = 3'(pw);
    b.vx = vx;
    b.vy = vy;
    b.vz = vz;
    send(b);
  endtask

  task automatic meta(logic [1:0] veh, logic [4:0] cnt, logic [47:0] ts);
    beat_t b;
    b = mk(ppte_pkg::REQ_META, veh);
    b.cnt = cnt;
    b.ts = ts;
    send(b);
  endtask

  // Build one full trajectory, then ask for positions across and around it.
  task automatic build_and_query(logic [1:0] veh);
    int n;
    logic [31:0] dur;
    logic [47:0] st, ts;
    longint sp;
    n = ($urandom_range(0, 9) == 0) ? ppte_pkg::MaxSegments : $urandom_range(1, 4);
    for (int s = 0; s < n; s++) begin
      case ($urandom_range(0, 9))
        0:       dur = 32'd0;
        1:       dur = $urandom;
        2:       dur = 32'hffffffff;
        default: dur = $urandom_range(1, 32'h80000);
      endcase
      header(veh, s, dur, 3'($urandom));
      for (int p = 0; p < NumPowers; p++)
        coefw(veh, s, p, rand_coef(), rand_coef(), rand_coef());
    end
    st = $urandom_range(0, 1) ? rand48() : 48'($urandom);
    meta(veh, (n == ppte_pkg::MaxSegments && $urandom_range(0, 1)) ?
              5'($urandom_range(17, 31)) : 5'(n), st);
    sp = sb.span(veh);
    repeat ($urandom_range(3, 8)) begin
      case ($urandom_range(0, 7))
        0:       ts = st - 48'($urandom_range(0, 1000));
        1:       ts = rand48();
        2:       ts = st + 48'(sp) + 48'($urandom_range(1, 32'h10000));
        default: ts = st + 48'({$urandom, $urandom} % (sp + 2));
      endcase
      query(veh, ts);
    end
  endtask

  initial begin
    beat_t b;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = ppte_pkg::REQ_HEADER;
    req_if.vehicle = '0;
    req_if.seg_index = '0;
    req_if.power = '0;
    req_if.value_x = '0;
    req_if.value_y = '0;
    req_if.value_z = '0;
    req_if.seg_duration = '0;
    req_if.seg_order = '0;
    req_if.seg_count = '0;
    req_if.time_stamp = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: fallback before any load, fallback extremes, a three segment
    // trajectory with an order above the maximum, a zero length segment and a
    // full length one, then before-start, boundary and past-end queries.
    query(2'd1, 48'd0);
    b = mk(ppte_pkg::REQ_FALLBACK, 2'd1);
    b.vx = 32'h7fffffff; b.vy = 32'h80000000; b.vz = 32'h0;
    send(b);
    query(2'd1, rand48());
    header(2'd1, 0, 32'h20000, 3'd7);
    header(2'd1, 1, 32'h0, 3'd2);
    header(2'd1, 2, 32'hffffffff, 3'd0);
    for (int p = 0; p < NumPowers; p++)
      coefw(2'd1, 0, p, 32'h7fffffff, 32'h80000000, 32'(p) << 16);
    for (int p = 0; p < 3; p++) coefw(2'd1, 1, p, 32'h10000, 32'hffff0000, 32'h8000);
    coefw(2'd1, 2, 0, 32'h12345678, 32'h80000000, 32'h7fffffff);
    coefw(2'd1, 2, 6, 32'h0, 32'h0, 32'h0);
    coefw(2'd1, 2, 7, 32'h0, 32'h0, 32'h0);
    for (int r = 5; r < 8; r++) send(mk(3'(r), 2'd1));
    meta(2'd1, 5'd3, 48'h1_0000_0000);
    query(2'd1, 48'd0);
    query(2'd1, 48'h1_0000_0000 + 48'h10000);
    query(2'd1, 48'h1_0000_0000 + 48'h20000);
    query(2'd1, 48'h1_0000_0000 + 48'h20001);
    query(2'd1, 48'hffff_ffff_ffff);
    meta(2'd1, 5'd31, 48'h0);
    query(2'd1, 48'h0);

    // Random: mostly complete trajectories, with stray loads and queries mixed in.
    while (items_sent < ItemTarget) begin
      if (items_sent > ItemTarget - 80) quiet = 1;
      case ($urandom_range(0, 9))
        0:       send(mk(3'($urandom), 2'($urandom)));
        1:       query(2'($urandom), rand48());
        2:       begin
          b = mk(ppte_pkg::REQ_FALLBACK, 2'($urandom));
          send(b);
        end
        default: build_and_query(2'($urandom));
      endcase
    end

    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.owed_pos.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_pos.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
